// ===== hdl/torus_signed_distance_assert.svh =====
// Assertion macros for the torus distance RTL, included by sdf_front.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef TORUS_SIGNED_DISTANCE_ASSERT_SVH
`define TORUS_SIGNED_DISTANCE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDF_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("torus distance assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SDF_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("torus distance assertion failed");

`endif

// ===== hdl/sdf_pkg.sv =====
// Package for the torus signed distance block: widths, register codes, reset values.
// Used by every module of the block; depends on nothing.
package sdf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int AXIS_FRAC = 16;

    localparam int COORD_W = 32;
    localparam int AXIS_W  = 18;
    localparam int RAD_W   = 31;
    localparam int Q_W     = 33;
    localparam int SQ_W    = 64;
    localparam int S_W     = 66;
    localparam int PR_W    = 51;
    localparam int DOT_W   = 53;
    localparam int H_W     = DOT_W - AXIS_FRAC;
    localparam int HM_W    = 36;
    localparam int H2_W    = 72;
    localparam int R2_W    = 66;
    localparam int RT1_W   = R2_W / 2;
    localparam int D_W     = 35;
    localparam int DM_W    = 34;
    localparam int D2_W    = 68;
    localparam int T_W     = 72;
    localparam int RT2_W   = T_W / 2;
    localparam int RES_W   = 38;
    localparam int IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_AXIS_X   = 3'd3,
        REG_AXIS_Y   = 3'd4,
        REG_AXIS_Z   = 3'd5,
        REG_MAJOR    = 3'd6,
        REG_MINOR    = 3'd7
    } reg_idx_t;

    localparam logic [AXIS_W-1:0] AXIS_ONE    = AXIS_W'(1) << AXIS_FRAC;
    localparam logic [RAD_W-1:0]  MAJOR_RESET = RAD_W'(1) << FRAC_BITS;
    localparam logic [RAD_W-1:0]  MINOR_RESET = RAD_W'(1) << (FRAC_BITS - 1);

    // Torus geometry as held in the configuration registers.
    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic signed [AXIS_W-1:0]  axis_x;
        logic signed [AXIS_W-1:0]  axis_y;
        logic signed [AXIS_W-1:0]  axis_z;
        logic [RAD_W-1:0]          major_radius;
        logic [RAD_W-1:0]          minor_radius;
    } cfg_t;

    // Pipeline advance and item valid, handed from one section to the next.
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

// ===== hdl/sdf_sqrt.sv =====
// Pipelined integer floor square root, one root bit per register stage.
// Depends on sdf_pkg for the pipeline control struct.
module sdf_sqrt #(
    parameter int IN_W   = 66,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sdf_pkg::pipe_ctl_t  ctl,
    input  logic [IN_W-1:0]     rad,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   root,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int N = IN_W / 2;

    logic [IN_W-1:0]   rad_a  [0:N];
    logic [N+1:0]      rem_a  [0:N];
    logic [N-1:0]      root_a [0:N];
    logic [SIDE_W-1:0] side_a [0:N];
    logic              vld_a  [0:N];

    assign rad_a[0]  = rad;
    assign rem_a[0]  = '0;
    assign root_a[0] = '0;
    assign side_a[0] = side_in;
    assign vld_a[0]  = ctl.valid;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N+1:0]      rem_sh;
        logic [N+1:0]      trial;
        logic              take;
        logic [IN_W-1:0]   rad_reg;
        logic [N+1:0]      rem_reg;
        logic [N-1:0]      root_reg;
        logic [SIDE_W-1:0] side_reg;
        logic              vld_reg;

        // Bring down the next two radicand bits and try appending a one to the root.
        assign rem_sh = {rem_a[k][N-1:0], rad_a[k][IN_W-1 -: 2]};
        assign trial  = {root_a[k], 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg <= vld_a[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rad_reg  <= {rad_a[k][IN_W-3:0], 2'b00};
                rem_reg  <= take ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_a[k][N-2:0], take};
                side_reg <= side_a[k];
            end
        end

        assign rad_a[k+1]  = rad_reg;
        assign rem_a[k+1]  = rem_reg;
        assign root_a[k+1] = root_reg;
        assign side_a[k+1] = side_reg;
        assign vld_a[k+1]  = vld_reg;
    end

    assign out_valid = vld_a[N];
    assign root      = root_a[N];
    assign side_out  = side_a[N];

endmodule

// ===== hdl/sdf_front.sv =====
// Front section: offset from center, squares, axis projection, radial square.
// Depends on sdf_pkg and the assertion macro header.
`include "torus_signed_distance_assert.svh"

module sdf_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sdf_pkg::pipe_ctl_t                     ctl,
    input  sdf_pkg::cfg_t                          cfg,
    input  logic signed [sdf_pkg::COORD_W-1:0]     point_x,
    input  logic signed [sdf_pkg::COORD_W-1:0]     point_y,
    input  logic signed [sdf_pkg::COORD_W-1:0]     point_z,
    output logic                                   out_valid,
    output logic [sdf_pkg::R2_W-1:0]               r2,
    output logic [sdf_pkg::H2_W-1:0]               h2
);

    localparam int QW = sdf_pkg::Q_W;
    localparam int CW = sdf_pkg::COORD_W;

    logic signed [QW-1:0]             qx_reg, qy_reg, qz_reg;
    logic [sdf_pkg::SQ_W-1:0]         sx_reg, sy_reg, sz_reg;
    logic signed [sdf_pkg::PR_W-1:0]  px_reg, py_reg, pz_reg;
    logic [sdf_pkg::S_W-1:0]          s3_reg, s4_reg;
    logic signed [sdf_pkg::H_W-1:0]   h_reg;
    logic [sdf_pkg::H2_W-1:0]         h2_reg, h2o_reg;
    logic [sdf_pkg::R2_W-1:0]         r2_reg;
    logic                             v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic [QW-1:0]                    mx, my, mz;
    logic signed [sdf_pkg::DOT_W-1:0] dot;
    logic [sdf_pkg::S_W-1:0]          s_sum;
    logic [sdf_pkg::H_W-1:0]          h_abs;

    // Magnitudes of the offset; they stay below 2^32.
    assign mx = qx_reg[QW-1] ? -qx_reg : qx_reg;
    assign my = qy_reg[QW-1] ? -qy_reg : qy_reg;
    assign mz = qz_reg[QW-1] ? -qz_reg : qz_reg;

    // Sum of squares and rounded projection, halves toward plus infinity.
    assign s_sum = sdf_pkg::S_W'(sx_reg) + sdf_pkg::S_W'(sy_reg) + sdf_pkg::S_W'(sz_reg);
    assign dot   = sdf_pkg::DOT_W'(px_reg) + sdf_pkg::DOT_W'(py_reg) + sdf_pkg::DOT_W'(pz_reg)
                 + (sdf_pkg::DOT_W'(1) << (sdf_pkg::AXIS_FRAC - 1));
    assign h_abs = h_reg[sdf_pkg::H_W-1] ? -h_reg : h_reg;

    // Valid bits travel with the data and hold while the pipeline stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            qx_reg  <= QW'(point_x) - QW'(cfg.center_x);
            qy_reg  <= QW'(point_y) - QW'(cfg.center_y);
            qz_reg  <= QW'(point_z) - QW'(cfg.center_z);
            sx_reg  <= mx[CW-1:0] * mx[CW-1:0];
            sy_reg  <= my[CW-1:0] * my[CW-1:0];
            sz_reg  <= mz[CW-1:0] * mz[CW-1:0];
            px_reg  <= qx_reg * cfg.axis_x;
            py_reg  <= qy_reg * cfg.axis_y;
            pz_reg  <= qz_reg * cfg.axis_z;
            s3_reg  <= s_sum;
            h_reg   <= dot[sdf_pkg::DOT_W-1:sdf_pkg::AXIS_FRAC];
            s4_reg  <= s3_reg;
            h2_reg  <= sdf_pkg::H2_W'(h_abs[sdf_pkg::HM_W-1:0] * h_abs[sdf_pkg::HM_W-1:0]);
            r2_reg  <= (sdf_pkg::H2_W'(s4_reg) <= h2_reg) ? '0
                     : sdf_pkg::R2_W'(sdf_pkg::H2_W'(s4_reg) - h2_reg);
            h2o_reg <= h2_reg;
        end
    end

    assign out_valid = v5_reg;
    assign r2        = r2_reg;
    assign h2        = h2o_reg;

    // A stall freezes the front valid bits; an advance loads the input valid.
    `SDF_ASSERT_NEXT(a_stall_holds, clk, rst_n, !ctl.en,
        $stable({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg}))
    `SDF_ASSERT_NEXT(a_load_item, clk, rst_n, ctl.en && ctl.valid, v1_reg)
    `SDF_ASSERT_NEXT(a_load_bubble, clk, rst_n, ctl.en && !ctl.valid, !v1_reg)

endmodule

// ===== hdl/torus_signed_distance.sv =====
// Top level of the torus signed distance block: configuration registers,
// front section, two square root pipelines and the saturating output stage.
// Depends on sdf_pkg, sdf_front and sdf_sqrt.
//
//  channel   direction  width  contents
//  s_axis    in         96     point_x, point_y, point_z
//  m_axis    out        32     signed_distance
//  cfg       in         3+32   register index, write data
//
// One point enters per cycle while s_tready is high; the pipeline depth is set
// mostly by the two bit-per-stage square roots.
// Reset clears the valid bits and loads the z axis, radius 1.0 and tube 0.5.
// While a result waits on m_tready the whole pipeline holds; s_tready is low
// exactly then.
module torus_signed_distance (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // point_x, point_y, point_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // signed_distance
);

    sdf_pkg::cfg_t      cfg_reg;
    sdf_pkg::pipe_ctl_t ctl_in, ctl_r2, ctl_t;

    logic                          en;
    logic                          fr_valid;
    logic [sdf_pkg::R2_W-1:0]      fr_r2;
    logic [sdf_pkg::H2_W-1:0]      fr_h2;
    logic                          rt1_valid;
    logic [sdf_pkg::RT1_W-1:0]     radial;
    logic [sdf_pkg::H2_W-1:0]      rt1_h2;
    logic                          rt2_valid;
    logic [sdf_pkg::RT2_W-1:0]     tube_dist;

    logic signed [sdf_pkg::D_W-1:0]  d;
    logic [sdf_pkg::D_W-1:0]         d_abs;
    logic [sdf_pkg::DM_W-1:0]        dm_reg;
    logic [sdf_pkg::D2_W-1:0]        d2_reg;
    logic [sdf_pkg::T_W-1:0]         t_reg;
    logic [sdf_pkg::H2_W-1:0]        hb1_reg, hb2_reg;
    logic                            b1_reg, b2_reg, b3_reg;
    logic signed [sdf_pkg::RES_W-1:0] res;
    logic [31:0]                     out_reg;
    logic                            out_vld_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x     <= '0;
            cfg_reg.center_y     <= '0;
            cfg_reg.center_z     <= '0;
            cfg_reg.axis_x       <= '0;
            cfg_reg.axis_y       <= '0;
            cfg_reg.axis_z       <= sdf_pkg::AXIS_ONE;
            cfg_reg.major_radius <= sdf_pkg::MAJOR_RESET;
            cfg_reg.minor_radius <= sdf_pkg::MINOR_RESET;
        end
        else if (cfg_we)
        begin
            case (sdf_pkg::reg_idx_t'(cfg_index))
                sdf_pkg::REG_CENTER_X: cfg_reg.center_x     <= cfg_data;
                sdf_pkg::REG_CENTER_Y: cfg_reg.center_y     <= cfg_data;
                sdf_pkg::REG_CENTER_Z: cfg_reg.center_z     <= cfg_data;
                sdf_pkg::REG_AXIS_X:   cfg_reg.axis_x       <= cfg_data[sdf_pkg::AXIS_W-1:0];
                sdf_pkg::REG_AXIS_Y:   cfg_reg.axis_y       <= cfg_data[sdf_pkg::AXIS_W-1:0];
                sdf_pkg::REG_AXIS_Z:   cfg_reg.axis_z       <= cfg_data[sdf_pkg::AXIS_W-1:0];
                sdf_pkg::REG_MAJOR:    cfg_reg.major_radius <= cfg_data[sdf_pkg::RAD_W-1:0];
                sdf_pkg::REG_MINOR:    cfg_reg.minor_radius <= cfg_data[sdf_pkg::RAD_W-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign ctl_in = '{en: en, valid: s_tvalid};

    sdf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_in),
        .cfg       (cfg_reg),
        .point_x   (s_tdata[31:0]),
        .point_y   (s_tdata[63:32]),
        .point_z   (s_tdata[95:64]),
        .out_valid (fr_valid),
        .r2        (fr_r2),
        .h2        (fr_h2)
    );

    assign ctl_r2 = '{en: en, valid: fr_valid};

    // Radial distance from the axis; the projection square rides alongside.
    sdf_sqrt #(
        .IN_W   (sdf_pkg::R2_W),
        .SIDE_W (sdf_pkg::H2_W)
    ) u_sqrt_radial (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_r2),
        .rad       (fr_r2),
        .side_in   (fr_h2),
        .out_valid (rt1_valid),
        .root      (radial),
        .side_out  (rt1_h2)
    );

    // Offset from the tube circle in the meridian plane.
    assign d     = sdf_pkg::D_W'(radial) - sdf_pkg::D_W'(cfg_reg.major_radius);
    assign d_abs = d[sdf_pkg::D_W-1] ? -d : d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg <= 1'b0;
            b2_reg <= 1'b0;
            b3_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_reg <= rt1_valid;
            b2_reg <= b1_reg;
            b3_reg <= b2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_reg  <= d_abs[sdf_pkg::DM_W-1:0];
            hb1_reg <= rt1_h2;
            d2_reg  <= dm_reg * dm_reg;
            hb2_reg <= hb1_reg;
            t_reg   <= sdf_pkg::T_W'(d2_reg) + hb2_reg;
        end
    end

    assign ctl_t = '{en: en, valid: b3_reg};

    // Distance to the tube circle.
    sdf_sqrt #(
        .IN_W   (sdf_pkg::T_W),
        .SIDE_W (1)
    ) u_sqrt_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_t),
        .rad       (t_reg),
        .side_in   (1'b0),
        .out_valid (rt2_valid),
        .root      (tube_dist),
        .side_out  ()
    );

    // Tube radius minus distance, saturated to 32 bits, into the output register.
    assign res = sdf_pkg::RES_W'(cfg_reg.minor_radius) - sdf_pkg::RES_W'(tube_dist);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= rt2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (res > sdf_pkg::RES_W'(32'sh7FFF_FFFF))
            begin
                out_reg <= 32'h7FFF_FFFF;
            end
            else if (res < -(sdf_pkg::RES_W'(1) <<< 31))
            begin
                out_reg <= 32'h8000_0000;
            end
            else
            begin
                out_reg <= res[31:0];
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== dv/tb_torus_signed_distance.sv =====
// Self-checking testbench for torus_signed_distance: streams 3-D points through the block
// and compares each signed distance against a fixed-point predictor of the torus geometry.
// Depends on sdf_pkg and the RTL of the block; reads no files.
module tb_torus_signed_distance;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // point_x, point_y, point_z
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // signed_distance

    // Torus geometry as the predictor sees it.
    logic signed [31:0] geo_center [3];
    logic signed [17:0] geo_axis [3];
    logic [30:0]        geo_major;
    logic [30:0]        geo_minor;

    logic [95:0]        point_queue [$];
    logic signed [31:0] distance_queue [$];
    int                 mismatches;
    int                 results_seen;
    int                 send_gap;
    int                 recv_gap;
    int                 hold_count;
    bit                 hold_done;
    bit                 no_idle;

    torus_signed_distance dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Floor square root of a 128-bit value.
    function automatic logic [63:0] floor_root(logic [127:0] n);
        logic [63:0]  r;
        logic [127:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = 128'(r | (64'd1 << b));
            if (c * c <= n)
                r = c[63:0];
        end
        return r;
    endfunction

    // Signed distance of one point to the configured torus, saturated to 32 bits.
    function automatic logic signed [31:0] torus_distance(logic [95:0] pt);
        longint       q;
        longint       dot;
        longint       hv;
        longint       dd;
        longint       res;
        logic [127:0] mag;
        logic [127:0] sum_sq;
        logic [127:0] h_sq;
        logic [127:0] rad_sq;
        logic [127:0] tube_sq;
        logic [63:0]  radial;
        logic [63:0]  tube_len;
        sum_sq = '0;
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            q = longint'($signed(pt[32*i +: 32])) - longint'(geo_center[i]);
            mag = 128'(q < 0 ? -q : q);
            sum_sq += mag * mag;
            dot += q * longint'(geo_axis[i]);
        end
        // Round the dot product to nearest, halves upward.
        hv = (dot + (64'sd1 <<< (sdf_pkg::AXIS_FRAC - 1))) >>> sdf_pkg::AXIS_FRAC;
        mag = 128'(hv < 0 ? -hv : hv);
        h_sq = mag * mag;
        rad_sq = (sum_sq <= h_sq) ? 128'd0 : sum_sq - h_sq;
        radial = floor_root(rad_sq);
        dd = longint'(radial) - longint'(geo_major);
        mag = 128'(dd < 0 ? -dd : dd);
        tube_sq = mag * mag + h_sq;
        tube_len = floor_root(tube_sq);
        res = longint'(geo_minor) - longint'(tube_len);
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return res[31:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end

    // Sender: offers queued points, records the expected distance on each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                distance_queue.insert(distance_queue.size(), torus_distance(s_tdata));
            if (s_tvalid && !s_tready)
            begin
                // Hold the current point until it is taken.
            end
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (point_queue.size() > 0)
            begin
                s_tdata  <= point_queue.pop_front();
                s_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, one long hold-off, and the result check.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_gap   <= 0;
            hold_count <= 0;
            hold_done  <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (distance_queue.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Unexpected result %0d", $signed(m_tdata));
                end
                else
                begin
                    logic signed [31:0] want;
                    want = distance_queue.pop_front();
                    if (want !== $signed(m_tdata))
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("Distance mismatch: expected %0d, got %0d",
                                     want, $signed(m_tdata));
                    end
                end
            end
            if (!hold_done && results_seen == 300)
            begin
                hold_count <= LONG_HOLD;
                hold_done  <= 1'b1;
                m_tready   <= 1'b0;
            end
            else if (hold_count > 0)
            begin
                hold_count <= hold_count - 1;
                m_tready   <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    task automatic write_reg(sdf_pkg::reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            sdf_pkg::REG_CENTER_X: geo_center[0] = value;
            sdf_pkg::REG_CENTER_Y: geo_center[1] = value;
            sdf_pkg::REG_CENTER_Z: geo_center[2] = value;
            sdf_pkg::REG_AXIS_X:   geo_axis[0] = value[17:0];
            sdf_pkg::REG_AXIS_Y:   geo_axis[1] = value[17:0];
            sdf_pkg::REG_AXIS_Z:   geo_axis[2] = value[17:0];
            sdf_pkg::REG_MAJOR:    geo_major = value[30:0];
            default:               geo_minor = value[30:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_torus(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                             logic [31:0] major, logic [31:0] minor);
        write_reg(sdf_pkg::REG_CENTER_X, cx);
        write_reg(sdf_pkg::REG_CENTER_Y, cy);
        write_reg(sdf_pkg::REG_CENTER_Z, cz);
        write_reg(sdf_pkg::REG_AXIS_X, ax);
        write_reg(sdf_pkg::REG_AXIS_Y, ay);
        write_reg(sdf_pkg::REG_AXIS_Z, az);
        write_reg(sdf_pkg::REG_MAJOR, major);
        write_reg(sdf_pkg::REG_MINOR, minor);
    endtask

    task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        point_queue.insert(point_queue.size(), {z, y, x});
    endtask

    // Let every queued point go through and every result come back.
    task automatic drain();
        while (point_queue.size() > 0 || distance_queue.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random coordinate: full range, near the center, or an extreme.
    function automatic logic [31:0] rand_coord(int axis_i);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom();
        if (r < 90)
            return geo_center[axis_i] + $signed($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
        return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    task automatic random_points(int n);
        for (int i = 0; i < n; i++)
            push_point(rand_coord(0), rand_coord(1), rand_coord(2));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        results_seen = 0;
        no_idle      = 1'b0;
        geo_center   = '{0, 0, 0};
        geo_axis     = '{18'sd0, 18'sd0, $signed(sdf_pkg::AXIS_ONE)};
        geo_major    = sdf_pkg::MAJOR_RESET;
        geo_minor    = sdf_pkg::MINOR_RESET;
        repeat (2) @(posedge clk);
        rst_n = 1'b1;

        // Directed: reset geometry, origin, on the axis, on the tube, extremes.
        push_point(0, 0, 0);
        push_point(0, 0, 32'h0001_0000);
        push_point(0, 0, 32'hFFFF_0000);
        push_point(32'h0001_0000, 0, 0);
        push_point(0, 32'h0001_8000, 0);
        push_point(32'h0000_8000, 0, 0);
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
        push_point(0, 0, 32'h7FFF_FFFF);
        push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
        random_points(150);
        drain();

        // Tilted unit axis, offset center.
        set_torus(32'h0010_0000, 32'hFFF0_0000, 32'h0003_0000,
                  32'h0000_B505, 32'h0000_0000, 32'h0000_B505,
                  32'h0004_0000, 32'h0001_0000);
        random_points(250);
        drain();

        // Negative axis, extreme center, smallest radii; no idling.
        no_idle = 1'b1;
        set_torus(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                  32'h0000_0000, 32'h3_0000, 32'h0000_0000, 1, 1);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        random_points(200);
        drain();
        no_idle = 1'b0;

        // Largest radii and a non-unit axis so rounding clamps the radial square.
        set_torus(0, 0, 0, 32'h1_0001, 32'h1_0001, 32'h1_0001,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        random_points(200);
        drain();

        // Axis registers at their raw extremes, arbitrary geometry.
        set_torus($urandom(), $urandom(), $urandom(), 32'h2_0000, 32'h1_FFFF, 32'h3_FFFF,
                  $urandom_range(1, 32'h7FFF_FFFF), $urandom_range(1, 32'h7FFF_FFFF));
        random_points(200);
        drain();

        // Several random geometries, mostly moderate in size.
        for (int p = 0; p < 4; p++)
        begin
            set_torus($urandom() >>> 8, $urandom() >>> 8, $urandom() >>> 8,
                      $urandom(), $urandom(), $urandom(),
                      $urandom_range(1, 32'h00FF_FFFF), $urandom_range(1, 32'h00FF_FFFF));
            random_points(175);
            drain();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
